// ===== rtl/rc4_variant_keystream_cipher_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the keystream cipher
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// -----------------------------------------------------------------------------
`ifndef RC4_VARIANT_KEYSTREAM_CIPHER_MACROS_SVH
`define RC4_VARIANT_KEYSTREAM_CIPHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RC4V_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> rhs) \
      else $error("assertion failed");
`define RC4V_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`else
`define RC4V_ASSERT_IMPL(label, clk, rst, lhs, rhs)
`define RC4V_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

// ===== rtl/rc4v_pkg.sv =====
// -----------------------------------------------------------------------------
// Keystream cipher package
// Request codes, constants and the control struct shared by the modules.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rc4v_pkg;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_REKEY = 2'd1;
   localparam logic [1:0] REQ_DATA  = 2'd2;

   localparam logic [7:0] KEY_STEP  = 8'd101;
   localparam logic [7:0] PERM_LAST = 8'hff;

   typedef struct packed {
      logic start;
      logic advance;
      logic rd_en;
   } key_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/rc4v_key_sched.sv =====
// -----------------------------------------------------------------------------
// Key schedule store
// Holds the raw key bytes and produces the adjusted key byte for each mix step.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rc4v_key_sched #(
   parameter int KEY_LEN = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [5:0]           wr_index,
   input  wire logic [7:0]           wr_byte,
   input  wire logic [7:0]           modifier,
   input  wire rc4v_pkg::key_ctl_type ctl,
   output logic      [7:0]           work_byte
);

   localparam int KW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

   logic [7:0]    key_mem [KEY_LEN];
   logic [8:0]    wr_ext;
   logic [KW-1:0] k_ff, k_in;
   logic [7:0]    mul_ff, mul_in;
   logic [7:0]    rd_ff;
   logic [7:0]    mul_q_ff;

   assign wr_ext = {3'b000, wr_index};

   always_comb begin
      k_in   = k_ff;
      mul_in = mul_ff;
      if (ctl.start) begin
         k_in   = '0;
         mul_in = '0;
      end else if (ctl.advance) begin
         if (k_ff == KW'(KEY_LEN - 1)) begin
            k_in   = '0;
            mul_in = '0;
         end else begin
            k_in   = k_ff + KW'(1);
            mul_in = mul_ff + rc4v_pkg::KEY_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= '0;
         mul_ff <= '0;
      end else begin
         k_ff   <= k_in;
         mul_ff <= mul_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_ext < 9'(KEY_LEN))) begin
         key_mem[wr_ext[KW-1:0]] <= wr_byte;
      end
      if (ctl.rd_en) begin
         rd_ff    <= key_mem[k_ff];
         mul_q_ff <= mul_ff;
      end
   end

   assign work_byte = rd_ff + mul_q_ff + modifier;

endmodule
`default_nettype wire

// ===== rtl/rc4v_out_buf.sv =====
// -----------------------------------------------------------------------------
// Result buffer
// A pending slot in front of the output register so work can go on under stall.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rc4_variant_keystream_cipher_macros.svh"
module rc4v_out_buf (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic [7:0] push_byte,
   output logic            pend,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_out_byte
);

   logic       pend_ff, pend_in;
   logic       valid_ff, valid_in;
   logic [7:0] res_ff;
   logic [7:0] out_ff;
   logic       load;

   assign load = pend_ff && (!valid_ff || !rsp_stall);

   always_comb begin
      pend_in  = pend_ff;
      valid_in = valid_ff;
      if (push) begin
         pend_in = 1'b1;
      end else if (load) begin
         pend_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         res_ff <= push_byte;
      end
      if (load) begin
         out_ff <= res_ff;
      end
   end

   assign pend         = pend_ff;
   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = out_ff;

   `RC4V_ASSERT_IMPL(a_no_overwrite, clock, reset, push, !pend_ff)
   `RC4V_ASSERT_NEXT(a_held_under_stall, clock, reset,
                     pend_ff && valid_ff && rsp_stall, pend_ff && valid_ff)

endmodule
`default_nettype wire

// ===== rtl/rc4_variant_keystream_cipher.sv =====
// -----------------------------------------------------------------------------
// RC4-like keystream cipher
// Key store, table rekey and per-item keystream around one permutation memory.
// -----------------------------------------------------------------------------
//   Channel   Ports                                  Direction
//   req       req_valid req_stall req_type ...        in
//   rsp       rsp_valid rsp_stall rsp_out_byte        out
//
// A key-load item is written to the key store when accepted; a data item
// runs through KS2 to KS5, a chain set by the dependent reads and the two swap
// writes on the single table write port. A rekey fills the table and runs
// MIX_PASSES passes of key read, table read, write, write swap steps.
// Reset clears the sequencer, the counter and the last index; the tables are
// undefined until key loads and a rekey fill them.
// A result held by rsp_stall stays in the output register while the next
// item is worked; a second result then waits and input is stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "rc4_variant_keystream_cipher_macros.svh"
module rc4_variant_keystream_cipher #(
   parameter int KEY_LEN    = 64,
   parameter int MIX_PASSES = 20
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_type,
   input  wire logic [5:0] req_key_index,
   input  wire logic [7:0] req_key_byte,
   input  wire logic [7:0] req_modifier,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_out_byte
);

   localparam int PW = (MIX_PASSES > 1) ? $clog2(MIX_PASSES) : 1;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_FILL    = 4'd1;
   localparam logic [3:0] ST_MIX_KEY = 4'd2;
   localparam logic [3:0] ST_MIX_RD  = 4'd3;
   localparam logic [3:0] ST_MIX_W1  = 4'd4;
   localparam logic [3:0] ST_MIX_W2  = 4'd5;
   localparam logic [3:0] ST_FIN1    = 4'd6;
   localparam logic [3:0] ST_FIN2    = 4'd7;
   localparam logic [3:0] ST_FIN3    = 4'd8;
   localparam logic [3:0] ST_FIN4    = 4'd9;
   localparam logic [3:0] ST_KS2     = 4'd10;
   localparam logic [3:0] ST_KS3     = 4'd11;
   localparam logic [3:0] ST_KS4     = 4'd12;
   localparam logic [3:0] ST_KS5     = 4'd13;

   logic [3:0]    state_ff, state_in;
   logic [7:0]    ctr_ff, ctr_in;
   logic [7:0]    last_ff, last_in;
   logic [7:0]    pos_ff, pos_in;
   logic [PW-1:0] pass_ff, pass_in;
   logic [7:0]    j_ff, j_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    data_ff, data_in;
   logic [7:0]    mod_ff, mod_in;

   logic [7:0]    perm_mem [256];
   logic [7:0]    rd_a_ff, rd_b_ff;
   logic          ra_en, rb_en, we;
   logic [7:0]    ra_addr, rb_addr, waddr, wdata;

   logic          accept;
   logic          pend;
   logic          push;
   logic [7:0]    push_byte;
   logic [7:0]    ks_byte;
   logic          key_wr;
   logic [7:0]    work_byte;
   logic          mix_end;
   rc4v_pkg::key_ctl_type key_ctl;

   assign req_stall = (state_ff != ST_IDLE) || pend;
   assign accept    = req_valid && !req_stall;
   assign key_wr    = accept && (req_type == rc4v_pkg::REQ_LOAD);
   assign ks_byte   = sum_ff ^ rd_a_ff;
   assign mix_end   = (pos_ff == rc4v_pkg::PERM_LAST) && (pass_ff == PW'(MIX_PASSES - 1));

   always_comb begin
      state_in  = state_ff;
      ctr_in    = ctr_ff;
      last_in   = last_ff;
      pos_in    = pos_ff;
      pass_in   = pass_ff;
      j_in      = j_ff;
      sum_in    = sum_ff;
      data_in   = data_ff;
      mod_in    = mod_ff;
      ra_en     = 1'b0;
      rb_en     = 1'b0;
      we        = 1'b0;
      ra_addr   = ctr_ff;
      rb_addr   = last_ff;
      waddr     = pos_ff;
      wdata     = pos_ff;
      push      = 1'b0;
      push_byte = data_ff ^ ks_byte;
      key_ctl   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  rc4v_pkg::REQ_REKEY: begin
                     mod_in        = req_modifier;
                     pos_in        = '0;
                     key_ctl.start = 1'b1;
                     state_in      = ST_FILL;
                  end
                  rc4v_pkg::REQ_DATA: begin
                     data_in  = req_data_byte;
                     ra_en    = 1'b1;
                     rb_en    = 1'b1;
                     state_in = ST_KS2;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            we     = 1'b1;
            pos_in = pos_ff + 8'd1;
            if (pos_ff == rc4v_pkg::PERM_LAST) begin
               pass_in  = '0;
               state_in = ST_MIX_KEY;
            end
         end
         ST_MIX_KEY: begin
            key_ctl.rd_en = 1'b1;
            state_in      = ST_MIX_RD;
         end
         ST_MIX_RD: begin
            j_in     = pos_ff + work_byte;
            ra_en    = 1'b1;
            ra_addr  = pos_ff;
            rb_en    = 1'b1;
            rb_addr  = pos_ff + work_byte;
            state_in = ST_MIX_W1;
         end
         ST_MIX_W1: begin
            we       = 1'b1;
            waddr    = pos_ff;
            wdata    = rd_b_ff;
            state_in = ST_MIX_W2;
         end
         ST_MIX_W2: begin
            we              = 1'b1;
            waddr           = j_ff;
            wdata           = rd_a_ff;
            key_ctl.advance = 1'b1;
            pos_in          = pos_ff + 8'd1;
            if (pos_ff == rc4v_pkg::PERM_LAST) begin
               pass_in = pass_ff + PW'(1);
            end
            state_in = mix_end ? ST_FIN1 : ST_MIX_KEY;
         end
         ST_FIN1: begin
            ra_en    = 1'b1;
            ra_addr  = 8'd1;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            ra_en    = 1'b1;
            ra_addr  = rd_a_ff;
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            ra_en    = 1'b1;
            ra_addr  = rd_a_ff;
            state_in = ST_FIN4;
         end
         ST_FIN4: begin
            last_in  = rd_a_ff;
            ctr_in   = '0;
            state_in = ST_IDLE;
         end
         ST_KS2: begin
            sum_in   = rd_a_ff + rd_b_ff;
            ra_en    = 1'b1;
            ra_addr  = last_ff ^ ctr_ff;
            state_in = ST_KS3;
         end
         ST_KS3: begin
            push     = 1'b1;
            ctr_in   = ctr_ff + 8'd1;
            ra_en    = 1'b1;
            ra_addr  = ks_byte;
            rb_en    = 1'b1;
            rb_addr  = ctr_ff + 8'd1;
            state_in = ST_KS4;
         end
         ST_KS4: begin
            last_in  = rd_a_ff;
            we       = 1'b1;
            waddr    = rd_a_ff;
            wdata    = rd_b_ff;
            ra_en    = 1'b1;
            ra_addr  = rd_a_ff;
            state_in = ST_KS5;
         end
         ST_KS5: begin
            we       = 1'b1;
            waddr    = ctr_ff;
            wdata    = rd_a_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctr_ff   <= '0;
         last_ff  <= '0;
         pos_ff   <= '0;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ctr_ff   <= ctr_in;
         last_ff  <= last_in;
         pos_ff   <= pos_in;
         pass_ff  <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      sum_ff  <= sum_in;
      data_ff <= data_in;
      mod_ff  <= mod_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         perm_mem[waddr] <= wdata;
      end
      if (ra_en) begin
         rd_a_ff <= perm_mem[ra_addr];
      end
      if (rb_en) begin
         rd_b_ff <= perm_mem[rb_addr];
      end
   end

   rc4v_key_sched #(
      .KEY_LEN (KEY_LEN)
   ) u_key_sched (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (key_wr),
      .wr_index  (req_key_index),
      .wr_byte   (req_key_byte),
      .modifier  (mod_ff),
      .ctl       (key_ctl),
      .work_byte (work_byte)
   );

   rc4v_out_buf u_out_buf (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_byte    (push_byte),
      .pend         (pend),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte)
   );

   `RC4V_ASSERT_IMPL(a_data_gives_result, clock, reset,
                     accept && (req_type == rc4v_pkg::REQ_DATA), ##2 push)
   `RC4V_ASSERT_NEXT(a_rekey_starts_fill, clock, reset,
                     accept && (req_type == rc4v_pkg::REQ_REKEY),
                     (state_ff == ST_FILL) && (pos_ff == 8'd0))
   `RC4V_ASSERT_IMPL(a_one_write_per_step, clock, reset,
                     state_ff == ST_MIX_RD, !we ##1 we ##1 we)

endmodule
`default_nettype wire
